// ===== hdl/sacl_pkg.sv =====
`timescale 1ns / 1ps

package sacl_pkg;

  // Address layout: block offset | set index | upper block bits
  localparam int ADDR_BITS   = 12;
  localparam int BLOCK_BYTES = 4;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = ADDR_BITS - OFF_W;
  localparam int SETS        = 16;
  localparam int SET_W       = $clog2(SETS);
  localparam int TICK_W      = 32;

endpackage

// ===== hdl/sacl_ram.sv =====
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/set_assoc_cache_lfu_lru.sv =====
`timescale 1ns / 1ps
// The result word is registered in the update state once the set is scanned;
// no new address is taken before then. The set is read one way per cycle
// through the single read port of the line store.
// Reset (rst_n low, synchronous) clears all valid bits, the access tick and
// the output valid flag; the line store itself is not cleared.
module set_assoc_cache_lfu_lru
  import sacl_pkg::*;
#(
  parameter int WAYS     = 16,
  parameter int USE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ADDR_BITS-1:0]                  in_address,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] out_way,
  output logic                                  out_evicted,
  output logic [ADDR_BITS-1:0]                  out_evicted_block
);

  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DEPTH   = SETS * (2 ** WAY_W);
  localparam int WORD_W  = BLK_W + USE_BITS + TICK_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_UPD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [DEPTH-1:0]     valid_r;
  logic [TICK_W-1:0]    tick_r;
  logic [BLK_W-1:0]     blk_r;
  logic [WAY_W-1:0]     rd_way_r;
  logic                 chk_v_r;
  logic [WAY_W-1:0]     chk_way_r;
  logic                 vld_q_r;

  logic                 hit_f_r;
  logic [WAY_W-1:0]     hit_way_r;
  logic [USE_BITS-1:0]  hit_uses_r;
  logic [BLK_W-1:0]     hit_blk_r;
  logic                 free_f_r;
  logic [WAY_W-1:0]     free_way_r;
  logic [WAY_W-1:0]     best_way_r;
  logic [USE_BITS-1:0]  best_uses_r;
  logic [TICK_W-1:0]    best_last_r;
  logic [BLK_W-1:0]     best_blk_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [WAY_W-1:0]     out_way_r;
  logic                 out_evicted_r;
  logic [ADDR_BITS-1:0] out_evicted_block_r;

  logic [SET_W-1:0]     set_idx;
  logic [WORD_W-1:0]    rd_data;
  logic [BLK_W-1:0]     rd_blk;
  logic [USE_BITS-1:0]  rd_uses;
  logic [TICK_W-1:0]    rd_last;
  logic                 wr_en;
  logic [WAY_W-1:0]     tgt_way;
  logic [WORD_W-1:0]    wr_data;
  logic [USE_BITS-1:0]  uses_inc;
  logic                 upd_go;
  logic                 better;
  logic                 match;

  assign set_idx = blk_r[SET_W-1:0];
  assign rd_blk  = rd_data[BLK_W-1:0];
  assign rd_uses = rd_data[BLK_W +: USE_BITS];
  assign rd_last = rd_data[BLK_W+USE_BITS +: TICK_W];

  assign in_ready = (state_r == S_IDLE);
  assign upd_go   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  sacl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({set_idx, tgt_way}),
    .wr_data (wr_data),
    .rd_addr ({set_idx, rd_way_r}),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (rd_way_r == WAY_W'(WAYS - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Replacement choice: hit way, else first free way, else LFU/LRU victim
  always_comb begin
    if (hit_f_r) begin
      tgt_way = hit_way_r;
    end else if (free_f_r) begin
      tgt_way = free_way_r;
    end else begin
      tgt_way = best_way_r;
    end
    uses_inc = (hit_uses_r == {USE_BITS{1'b1}}) ? hit_uses_r : hit_uses_r + 1'b1;
    if (hit_f_r) begin
      wr_data = {tick_r, uses_inc, hit_blk_r};
    end else begin
      wr_data = {tick_r, {USE_BITS{1'b0}}, blk_r};
    end
    wr_en = upd_go;
  end

  assign match  = vld_q_r && (rd_blk == blk_r);
  assign better = (chk_way_r == '0) || (rd_uses < best_uses_r) ||
                  ((rd_uses == best_uses_r) && (rd_last < best_last_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      tick_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hit_f_r     <= 1'b0;
      free_f_r    <= 1'b0;
      rd_way_r    <= '0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= (state_r == S_SCAN);

      if (out_valid_r && out_ready && !upd_go) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rd_way_r <= '0;
            hit_f_r  <= 1'b0;
            free_f_r <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_way_r <= rd_way_r + 1'b1;
        end
        S_UPD: begin
          if (upd_go) begin
            valid_r[{set_idx, tgt_way}] <= 1'b1;
            tick_r      <= tick_r + 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase

      // one way of the set checked per cycle as its word comes back
      if (chk_v_r) begin
        if (!hit_f_r && match) begin
          hit_f_r <= 1'b1;
        end
        if (!free_f_r && !vld_q_r) begin
          free_f_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r   <= valid_r[{set_idx, rd_way_r}];
    chk_way_r <= rd_way_r;

    if (state_r == S_IDLE && in_valid) begin
      blk_r <= in_address[ADDR_BITS-1:OFF_W];
    end

    if (chk_v_r) begin
      if (!hit_f_r && match) begin
        hit_way_r  <= chk_way_r;
        hit_uses_r <= rd_uses;
        hit_blk_r  <= rd_blk;
      end
      if (!free_f_r && !vld_q_r) begin
        free_way_r <= chk_way_r;
      end
      if (better) begin
        best_way_r  <= chk_way_r;
        best_uses_r <= rd_uses;
        best_last_r <= rd_last;
        best_blk_r  <= rd_blk;
      end
    end

    if (upd_go) begin
      out_hit_r     <= hit_f_r;
      out_way_r     <= tgt_way;
      out_evicted_r <= !hit_f_r && !free_f_r;
      if (!hit_f_r && !free_f_r) begin
        out_evicted_block_r <= {best_blk_r, {OFF_W{1'b0}}};
      end else begin
        out_evicted_block_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_way           = out_way_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_block = out_evicted_block_r;

endmodule
